### hdl/orb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orb_pkg
// Types and constants shared by the overwriting ring buffer unit and its
// users: command codes and the request and response beat layouts.
// ----------------------------------------------------------------------------
package orb_pkg;

   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;
   localparam int CSR_W      = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH        = 2'd0,
      CMD_READ_LATEST = 2'd1,
      CMD_READ_AT     = 2'd2,
      CMD_CLEAR       = 2'd3
   } orb_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [VALUE_W-1:0]    value;
      logic [POSITION_W-1:0] position;
   } orb_req_type;

   typedef struct packed {
      logic                  ok;
      logic [VALUE_W-1:0]    read_data;
      logic [COUNT_W-1:0]    fill_count;
      logic                  is_empty;
      logic                  is_full;
   } orb_rsp_type;

endpackage : orb_pkg
`default_nettype wire

### hdl/overwriting_ring_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_unit
// History ring buffer that overwrites its oldest element once the depth in
// use is reached. Elements live in one single-port synchronous memory.
// ----------------------------------------------------------------------------
// Every command gives its result beat in the cycle after it is taken.
// Throughput: one command per cycle; each command uses the memory port at most
// once (a write for push, a read for the two reads), so busy stays low.
// Reset (synchronous): oldest pointer and count go to zero and the depth in
// use to DEPTH, at most 64; memory contents stay undefined until pushed.
// Result beats show on rsp_strobe for one cycle; the receiver cannot stall.
module overwriting_ring_buffer_unit #(
   parameter int DEPTH        = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  orb_pkg::orb_req_type      req_data,
   output logic                      rsp_strobe,
   output orb_pkg::orb_rsp_type      rsp_data,
   input  wire                       csr_write_en,
   input  wire [orb_pkg::CSR_W-1:0]  csr_write_data
);
   import orb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = (CW > CSR_W) ? CW : CSR_W;
   localparam int AW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
   localparam logic [CW-1:0] RESET_DEPTH = CW'((DEPTH < 64) ? DEPTH : 64);

   logic [ELEMENT_BITS-1:0] mem [DEPTH];
   logic [ELEMENT_BITS-1:0] mem_q_ff;

   logic [PW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] depth_ff, depth_in;

   logic          valid_ff, valid_in;
   logic          ok_ff, ok_in;
   logic          is_read_ff, is_read_in;
   logic [CW-1:0] fill_ff;
   logic          empty_ff, full_ff;

   logic          accept;
   logic          mem_we, mem_re;
   logic [PW-1:0] mem_idx;
   logic [DW-1:0] csr_wide;
   logic [AW-1:0] oldest_w, held_w, depth_w, pos_w;

   // Sum is below twice the depth whenever the index is used, so one subtraction wraps it.
   function automatic logic [PW-1:0] wrap_idx(input logic [AW-1:0] a,
                                              input logic [AW-1:0] d);
      logic [AW-1:0] r;
      r = (a >= d) ? (a - d) : a;
      return PW'(r);
   endfunction

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign oldest_w = AW'(oldest_ff);
   assign held_w   = AW'(held_ff);
   assign depth_w  = AW'(depth_ff);
   assign pos_w    = AW'(req_data.position);
   assign csr_wide = DW'(csr_write_data);

   always_comb begin
      oldest_in  = oldest_ff;
      held_in    = held_ff;
      depth_in   = depth_ff;
      valid_in   = accept;
      ok_in      = 1'b1;
      is_read_in = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_idx    = wrap_idx(oldest_w + held_w, depth_w);

      if (csr_write_en) begin
         // A depth write also empties the buffer.
         if (csr_wide == '0) begin
            depth_in = CW'(1);
         end else if (csr_wide > DW'(DEPTH)) begin
            depth_in = CW'(DEPTH);
         end else begin
            depth_in = CW'(csr_wide);
         end
         oldest_in = '0;
         held_in   = '0;
      end else if (accept) begin
         case (orb_cmd_type'(req_data.command))
            CMD_PUSH: begin
               mem_we = 1'b1;
               if (held_ff < depth_ff) begin
                  held_in = CW'(held_w + AW'(1));
               end else begin
                  oldest_in = wrap_idx(oldest_w + AW'(1), depth_w);
               end
            end
            CMD_READ_LATEST: begin
               is_read_in = 1'b1;
               ok_in      = (held_ff != '0);
               mem_re     = ok_in;
               mem_idx    = wrap_idx(oldest_w + held_w - AW'(1), depth_w);
            end
            CMD_READ_AT: begin
               is_read_in = 1'b1;
               ok_in      = (pos_w < held_w);
               mem_re     = ok_in;
               mem_idx    = wrap_idx(oldest_w + pos_w, depth_w);
            end
            CMD_CLEAR: begin
               oldest_in = '0;
               held_in   = '0;
            end
            default: begin
               ok_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_idx] <= ELEMENT_BITS'(req_data.value);
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         oldest_ff <= '0;
         held_ff   <= '0;
         depth_ff  <= RESET_DEPTH;
      end else begin
         valid_ff  <= valid_in;
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
         depth_ff  <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff      <= ok_in;
      is_read_ff <= is_read_in;
      fill_ff    <= held_in;
      empty_ff   <= (held_in == '0);
      full_ff    <= (held_in == depth_ff);
   end

   always_comb begin
      rsp_strobe          = valid_ff;
      rsp_data.ok         = ok_ff;
      rsp_data.read_data  = (ok_ff && is_read_ff) ? VALUE_W'(mem_q_ff) : '0;
      rsp_data.fill_count = COUNT_W'(fill_ff);
      rsp_data.is_empty   = empty_ff;
      rsp_data.is_full    = full_ff;
   end

endmodule : overwriting_ring_buffer_unit
`default_nettype wire

### tb/sv/overwriting_ring_buffer_unit_test.sv
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_unit_test
// Self-checking bench for the overwriting ring buffer unit. Commands are sent
// through the start/busy port, the depth in use is changed between phases,
// and every response beat is compared field by field with a scoreboard that
// keeps its own copy of the buffer contents, pointers and depth.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_unit_test;
   import orb_pkg::*;

   localparam int SLOT_COUNT     = 64;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   orb_req_type          req_data       = '0;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_W-1:0]     csr_write_data = '0;
   wire                  busy;
   wire                  rsp_strobe;
   orb_rsp_type          rsp_data;

   // Scoreboard: mirrors the buffer and queues the response each command owes.
   class history_scoreboard;
      logic [VALUE_W-1:0] slot_mem [SLOT_COUNT];
      int unsigned        oldest    = 0;
      int unsigned        held      = 0;
      int unsigned        depth_reg = SLOT_COUNT;
      int unsigned        mismatches = 0;
      orb_rsp_type        owed_rsp [$];

      function int unsigned active_depth();
         if (depth_reg == 0) return 1;
         if (depth_reg > SLOT_COUNT) return SLOT_COUNT;
         return depth_reg;
      endfunction

      function int unsigned wrap(int unsigned a, int unsigned d);
         return (a >= d) ? a - d : a;
      endfunction

      function int unsigned pending();
         return owed_rsp.size();
      endfunction

      function void write_depth(logic [CSR_W-1:0] v);
         depth_reg = v;
         oldest    = 0;
         held      = 0;
      endfunction

      function void note_command(orb_req_type r);
         orb_rsp_type want;
         int unsigned d;
         want    = '0;
         want.ok = 1'b1;
         d       = active_depth();
         case (r.command)
            CMD_PUSH: begin
               slot_mem[wrap(oldest + held, d)] = r.value;
               if (held < d) held++;
               else oldest = wrap(oldest + 1, d);
            end
            CMD_READ_LATEST: begin
               if (held == 0) want.ok = 1'b0;
               else want.read_data = slot_mem[wrap(oldest + held - 1, d)];
            end
            CMD_READ_AT: begin
               if (r.position >= held) want.ok = 1'b0;
               else want.read_data = slot_mem[wrap(oldest + r.position, d)];
            end
            default: begin
               oldest = 0;
               held   = 0;
            end
         endcase
         want.fill_count = COUNT_W'(held);
         want.is_empty   = (held == 0);
         want.is_full    = (held == d);
         owed_rsp.push_back(want);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(orb_rsp_type got);
         orb_rsp_type want;
         if (owed_rsp.size() == 0) begin
            $error("response beat with no command outstanding");
            mismatches++;
            return;
         end
         want = owed_rsp.pop_front();
         compare_field("ok", want.ok, got.ok);
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("fill_count", want.fill_count, got.fill_count);
         compare_field("is_empty", want.is_empty, got.is_empty);
         compare_field("is_full", want.is_full, got.is_full);
      endfunction
   endclass

   history_scoreboard sb = new;

   // Rough view of the fill level, used only to steer positions and commands.
   int unsigned fill_guess  = 0;
   int unsigned depth_guess = SLOT_COUNT;
   int unsigned quiet_cycles = 0;

   overwriting_ring_buffer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Values are sampled at the edge, before the block updates its outputs.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1) sb.check_response(rsp_data);
         if (start && busy === 1'b0) sb.note_command(req_data);
         if (csr_write_en) sb.write_depth(csr_write_data);
         if (rsp_strobe === 1'b1 || (start && busy === 1'b0) || csr_write_en) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("overwriting_ring_buffer_unit_test: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_command(input orb_cmd_type cmd, input logic [VALUE_W-1:0] value,
                               input logic [POSITION_W-1:0] position);
      orb_req_type r;
      r.command  = cmd;
      r.value    = value;
      r.position = position;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      case (cmd)
         CMD_PUSH:  if (fill_guess < depth_guess) fill_guess++;
         CMD_CLEAR: fill_guess = 0;
         default: ;
      endcase
   endtask

   // A stale count only delays the exit, so reading it at the edge is safe.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic set_depth(input logic [CSR_W-1:0] v);
      wait_for_drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      depth_guess = (v == 0) ? 1 : ((v > SLOT_COUNT) ? SLOT_COUNT : v);
      fill_guess  = 0;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] depth_value, input int unsigned n_beats,
                            input bit no_idle);
      int unsigned        idle_pct;
      int unsigned        pick;
      int unsigned        push_pct;
      orb_cmd_type        cmd;
      logic [VALUE_W-1:0] value;
      logic [POSITION_W-1:0] position;
      set_depth(depth_value);
      idle_pct = no_idle ? 0 : 10 * $urandom_range(0, 4);
      for (int i = 0; i < n_beats; i++) begin
         value    = $urandom;
         position = $urandom_range(0, SLOT_COUNT - 1);
         pick     = $urandom_range(0, 15);
         if (pick == 0) value = '0;
         else if (pick == 1) value = '1;
         // Lean on pushes until full so the overwrite path gets exercised.
         push_pct = (fill_guess < depth_guess) ? 60 : 40;
         pick = $urandom_range(0, 999);
         if (pick < 10 * push_pct) begin
            cmd = CMD_PUSH;
         end else if (pick < 10 * push_pct + 200) begin
            cmd = CMD_READ_LATEST;
         end else if (pick < ((depth_guess > 16) ? 990 : 960)) begin
            cmd = CMD_READ_AT;
            if (fill_guess != 0 && $urandom_range(0, 3) != 0)
               position = $urandom_range(0, fill_guess - 1);
         end else begin
            cmd = CMD_CLEAR;
         end
         if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         if (!no_idle && $urandom_range(0, 149) == 0) wait_for_drain();
         send_command(cmd, value, position);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reads on an empty buffer, both value extremes, a failing position read.
      send_command(CMD_READ_LATEST, 32'h0, '0);
      send_command(CMD_READ_AT, 32'h0, '0);
      send_command(CMD_READ_AT, 32'h0, '1);
      send_command(CMD_PUSH, '0, '0);
      send_command(CMD_PUSH, '1, '1);
      send_command(CMD_READ_LATEST, '1, '1);
      send_command(CMD_READ_AT, '0, 6'd0);
      send_command(CMD_READ_AT, '0, 6'd1);
      send_command(CMD_READ_AT, '0, 6'd2);
      send_command(CMD_CLEAR, '1, '1);
      send_command(CMD_READ_LATEST, '0, '0);

      // A depth of zero behaves as a single slot, so the second push overwrites.
      set_depth('0);
      send_command(CMD_PUSH, 32'hA5A5_A5A5, '0);
      send_command(CMD_PUSH, 32'h5A5A_5A5A, '0);
      send_command(CMD_READ_LATEST, '0, '0);
      send_command(CMD_READ_AT, '0, 6'd0);
      send_command(CMD_READ_AT, '0, 6'd1);

      // Two slots: the third push wraps the write index and moves the oldest pointer.
      set_depth(7'd2);
      send_command(CMD_PUSH, 32'h1, '0);
      send_command(CMD_PUSH, 32'h2, '0);
      send_command(CMD_PUSH, 32'h3, '0);
      send_command(CMD_READ_AT, '0, 6'd0);
      send_command(CMD_READ_AT, '0, 6'd1);
      send_command(CMD_READ_AT, '0, '1);
      send_command(CMD_CLEAR, '0, '0);

      run_phase(7'd1, 32, 1'b0);
      run_phase(7'd2, 34, 1'b0);
      run_phase(7'd3, 36, 1'b0);
      run_phase(7'd64, 140, 1'b0);
      run_phase(7'd127, 140, 1'b0);
      run_phase(CSR_W'($urandom_range(4, 40)), 60, 1'b0);
      run_phase(7'd0, 32, 1'b0);
      run_phase(7'd65, 60, 1'b1);

      wait_for_drain();
      repeat (3) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("overwriting_ring_buffer_unit_test: done, clean");
      end else begin
         $display("overwriting_ring_buffer_unit_test: done, errors");
      end
      $finish;
   end

endmodule
